### rtl/call_stack_exclusive_time_assert.svh
`ifndef CALL_STACK_EXCLUSIVE_TIME_ASSERT_SVH
`define CALL_STACK_EXCLUSIVE_TIME_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CSET_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("cset assertion failed");

// next-cycle implication, checked outside reset
`define CSET_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("cset assertion failed");

`endif

### rtl/cset_pkg.sv
package cset_pkg;

    localparam int NUM_FUNCS_DEF   = 64;
    localparam int STACK_DEPTH_DEF = 64;

    localparam int ID_W    = 6;
    localparam int TS_W    = 32;
    localparam int CHILD_W = 33;
    localparam int LVL_W   = 7;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_LATE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [TS_W-1:0]    ts;
        logic [CHILD_W-1:0] child;
    } t_frame;

    typedef struct packed {
        logic en;
        logic push;
        logic pop;
        logic credit;
    } t_stk_ctl;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] data;
    } t_tot_wr;

endpackage

### rtl/call_stack_exclusive_time.sv
// channel  | dir | handshake               | payload
// ---------+-----+-------------------------+------------------------------------------
// s (in)   | in  | i_s_tvalid / o_s_tready | tdata: func_id, timestamp; tuser: mode
// m (out)  | out | o_m_tvalid / i_m_tready | tdata: func_id_out, interval_excl,
//          |     |                         |   total_excl, stack_level; tuser: status
//
// one beat in, one beat out; a beat can be taken every cycle while the result is not stalled
// a beat goes through the input register, then one pass through the frame
// and total update into the result register
// the totals table and the stack are ready straight out of reset, no clearing pass
// a stalled result holds the pipe; the input register still fills behind it
`include "call_stack_exclusive_time_assert.svh"

module call_stack_exclusive_time
    import cset_pkg::*;
#(
    parameter int NUM_FUNCS   = NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // [5:0] func_id, [37:6] timestamp
    input  logic [1:0]  i_s_tuser,  // [1:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,  // [5:0] func_id_out, [37:6] interval_excl,
                                    // [69:38] total_excl, [76:70] stack_level
    output logic [1:0]  o_m_tuser   // [1:0] status
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    // input register
    logic            r_in_vld;
    t_mode           r_in_mode;
    logic [ID_W-1:0] r_in_id;
    logic [TS_W-1:0] r_in_ts;

    // result register
    logic             r_out_vld;
    logic [ID_W-1:0]  r_out_id;
    logic [TS_W-1:0]  r_out_excl;
    logic [TS_W-1:0]  r_out_total;
    logic [LVL_W-1:0] r_out_lvl;
    t_status          r_out_stat;

    logic              w_adv;
    logic              w_proc;
    logic              w_accept;
    logic [SP_W-1:0]   w_sp;
    t_frame            w_top;
    t_stk_ctl          w_stk_ctl;
    t_tot_wr           w_tot_wr;
    logic [TS_W-1:0]   w_tot_rd;

    logic              w_is_start;
    logic              w_is_end;
    logic              w_full;
    logic              w_empty;
    logic              w_late;
    logic              w_good_end;
    logic              w_in_range;
    logic [CHILD_W-1:0] w_interval;
    logic [CHILD_W-1:0] w_excl;
    logic [TS_W-1:0]   w_excl_sat;
    logic [TS_W-1:0]   w_base;
    logic [TS_W:0]     w_sum;
    logic [TS_W-1:0]   w_sum_sat;
    logic [TS_W-1:0]   w_total;
    logic [SP_W-1:0]   w_new_sp;
    t_status           w_stat;

    assign w_adv      = !r_out_vld || i_m_tready;
    assign w_proc     = r_in_vld && w_adv;
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_mode <= t_mode'(i_s_tuser);
            r_in_id   <= i_s_tdata[ID_W-1:0];
            r_in_ts   <= i_s_tdata[ID_W+TS_W-1:ID_W];
        end
    end

    // frame arithmetic
    assign w_is_start = (r_in_mode == MODE_START);
    assign w_is_end   = (r_in_mode == MODE_END);
    assign w_full     = (w_sp == SP_W'(STACK_DEPTH));
    assign w_empty    = (w_sp == '0);
    assign w_late     = (r_in_ts < w_top.ts);
    assign w_good_end = w_is_end && !w_empty && !w_late;
    assign w_in_range = (32'(r_in_id) < 32'(NUM_FUNCS));

    assign w_interval = {1'b0, r_in_ts} - {1'b0, w_top.ts} + CHILD_W'(1);
    assign w_excl     = (w_top.child > w_interval) ? '0 : (w_interval - w_top.child);
    assign w_excl_sat = w_excl[CHILD_W-1] ? '1 : w_excl[TS_W-1:0];

    assign w_base    = w_in_range ? w_tot_rd : '0;
    assign w_sum     = {1'b0, w_base} + {1'b0, w_excl_sat};
    assign w_sum_sat = w_sum[TS_W] ? '1 : w_sum[TS_W-1:0];
    assign w_total   = (w_good_end && w_in_range) ? w_sum_sat : w_base;

    always_comb begin
        w_stat = ST_OK;
        unique case (r_in_mode)
            MODE_START: begin
                if (w_full) begin
                    w_stat = ST_FULL;
                end
            end
            MODE_END: begin
                if (w_empty) begin
                    w_stat = ST_EMPTY;
                end else if (w_late) begin
                    w_stat = ST_LATE;
                end
            end
            default: begin
                w_stat = ST_OK;
            end
        endcase
    end

    always_comb begin
        w_stk_ctl.en     = w_proc;
        w_stk_ctl.push   = w_proc && w_is_start && !w_full;
        w_stk_ctl.pop    = w_proc && w_is_end && !w_empty;
        w_stk_ctl.credit = w_good_end && (w_sp > SP_W'(1));
        w_tot_wr.en      = w_proc && w_good_end && w_in_range;
        w_tot_wr.id      = r_in_id;
        w_tot_wr.data    = w_sum_sat;
    end

    assign w_new_sp = w_stk_ctl.push ? (w_sp + SP_W'(1)) :
                      w_stk_ctl.pop  ? (w_sp - SP_W'(1)) : w_sp;

    cset_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_stk_ctl),
        .i_ts       (r_in_ts),
        .i_interval (w_interval),
        .o_sp       (w_sp),
        .o_top      (w_top)
    );

    cset_totals #(
        .NUM_FUNCS (NUM_FUNCS)
    ) u_totals (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_id   (i_s_tdata[ID_W-1:0]),
        .i_wr      (w_tot_wr),
        .o_rd_data (w_tot_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proc) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_id    <= r_in_id;
            r_out_excl  <= w_good_end ? w_excl_sat : '0;
            r_out_total <= w_total;
            r_out_lvl   <= LVL_W'(w_new_sp);
            r_out_stat  <= w_stat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out_lvl, r_out_total, r_out_excl, r_out_id};
    assign o_m_tuser  = r_out_stat;

    `CSET_ASSERT_IMPL(a_sp_bound, 1'b1, w_sp <= SP_W'(STACK_DEPTH))
    `CSET_ASSERT_IMPL(a_err_no_excl, o_m_tvalid && (r_out_stat != ST_OK), r_out_excl == '0)
    `CSET_ASSERT_IMPL(a_empty_level, o_m_tvalid && (r_out_stat == ST_EMPTY), r_out_lvl == '0)
    `CSET_ASSERT_NEXT(a_push_grows, w_stk_ctl.push, w_sp == ($past(w_sp) + SP_W'(1)))

endmodule

### rtl/cset_stack.sv
module cset_stack
    import cset_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_stk_ctl                             i_ctl,
    input  logic [TS_W-1:0]                      i_ts,
    input  logic [CHILD_W-1:0]                   i_interval,
    output logic [$clog2(STACK_DEPTH+1)-1:0]     o_sp,
    output t_frame                               o_top
);

    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);

    // top frame lives in flops, frames below it in the array,
    // the one right under the top is kept prefetched in r_below
    t_frame            r_mem [STACK_DEPTH];
    logic [SP_W-1:0]   r_sp;
    t_frame            r_top;
    t_frame            r_below;

    logic [SP_W-1:0]   n_sp;
    t_frame            n_top;
    logic              w_wr;
    logic [SIDX_W-1:0] w_wr_addr;
    logic [SIDX_W-1:0] w_rd_addr;
    logic [CHILD_W:0]  w_child_sum;

    assign w_child_sum = {1'b0, r_below.child} + {1'b0, i_interval};

    always_comb begin
        n_sp  = r_sp;
        n_top = r_top;
        if (i_ctl.push) begin
            n_sp     = r_sp + SP_W'(1);
            n_top.ts = i_ts;
            n_top.child = '0;
        end else if (i_ctl.pop) begin
            n_sp  = r_sp - SP_W'(1);
            n_top = r_below;
            if (i_ctl.credit) begin
                n_top.child = w_child_sum[CHILD_W] ? '1 : w_child_sum[CHILD_W-1:0];
            end
        end
    end

    assign w_wr      = i_ctl.push && (r_sp != '0);
    assign w_wr_addr = SIDX_W'(r_sp - SP_W'(1));
    assign w_rd_addr = SIDX_W'(n_sp - SP_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_ctl.en) begin
            r_sp <= n_sp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_top <= n_top;
            if (w_wr) begin
                r_mem[w_wr_addr] <= r_top;
            end
            // read-during-write bypass on push
            if (w_wr && (w_wr_addr == w_rd_addr)) begin
                r_below <= r_top;
            end else begin
                r_below <= r_mem[w_rd_addr];
            end
        end
    end

    assign o_sp  = r_sp;
    assign o_top = r_top;

endmodule

### rtl/cset_totals.sv
module cset_totals
    import cset_pkg::*;
#(
    parameter int NUM_FUNCS = NUM_FUNCS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [ID_W-1:0] i_rd_id,
    input  t_tot_wr         i_wr,
    output logic [TS_W-1:0] o_rd_data
);

    localparam int FIDX_W = $clog2(NUM_FUNCS);

    logic [TS_W-1:0]      r_mem [NUM_FUNCS];
    logic [NUM_FUNCS-1:0] r_vld;
    logic [TS_W-1:0]      r_rd_data;

    logic [FIDX_W-1:0]    w_rd_idx;
    logic [FIDX_W-1:0]    w_wr_idx;

    assign w_rd_idx = FIDX_W'(i_rd_id);
    assign w_wr_idx = FIDX_W'(i_wr.id);

    // an entry never written since reset reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[w_wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[w_wr_idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.id == i_rd_id)) begin
                r_rd_data <= i_wr.data;
            end else if (r_vld[w_rd_idx]) begin
                r_rd_data <= r_mem[w_rd_idx];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
